/* rtl/core/lsfe_pkg.sv */
// Shared types, constants and an arithmetic helper for the LED strip frame encoder.
package lsfe_pkg;

    localparam int MAX_PIXELS   = 32;
    localparam int STRIP_LENGTH = 32;
    localparam int PIX_AW       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PIX_W        = 24;
    localparam int COUNT_W      = 6;
    localparam int POS_W        = 6;
    localparam int BRIGHT_W     = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    localparam logic [POS_W-1:0]    LAST_POS    = POS_W'(STRIP_LENGTH - 1);
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 7'd100;
    localparam logic [9:0]          HUE_MAX     = 10'd359;
    localparam logic [12:0]         DIV100_MUL  = 13'd5243;
    localparam int                  DIV100_SHIFT = 19;

    // command codes
    localparam logic [2:0] CMD_SET_RGB = 3'd0;
    localparam logic [2:0] CMD_SET_HSV = 3'd1;
    localparam logic [2:0] CMD_FILL    = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_SHOW    = 3'd4;
    localparam logic [2:0] CMD_RELEASE = 3'd5;
    localparam logic [2:0] CMD_FLUSH   = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] index;
        logic [7:0] end_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
        logic       link_busy;
    } item_t;

    typedef struct packed {
        logic [23:0]      grb_word;
        logic [POS_W-1:0] led_position;
        logic             last;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCALE_MUL,
        OP_SCALE_DIV,
        OP_HSV1,
        OP_HSV2,
        OP_HSV3,
        OP_HSV4,
        OP_WRITE,
        OP_SEND
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   clear_store;
        dp_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic write_ok;
        logic fill_last;
        logic send_last;
    } dp_status_t;

    // x / 255 for x below 65280 (the quotient fits in 8 bits)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

/* rtl/core/lsfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lsfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lsfe_datapath.sv */
// Datapath: config registers, color arithmetic, pixel store and frame output stage.
module lsfe_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lsfe_pkg::item_t                  item,
    input  logic                             cfg_we,
    input  logic [lsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  lsfe_pkg::ctrl_t                  ctrl,
    output lsfe_pkg::dp_status_t             status,
    output logic                             result_valid,
    output lsfe_pkg::result_t                result
);

    logic [lsfe_pkg::COUNT_W-1:0]    count_reg;
    logic [lsfe_pkg::BRIGHT_W-1:0]   bright_reg;
    logic [lsfe_pkg::COUNT_W-1:0]    ptr_reg;
    logic [lsfe_pkg::COUNT_W-1:0]    end_reg;
    logic [lsfe_pkg::MAX_PIXELS-1:0] vld_reg;
    logic                            s1_valid_reg;
    logic                            s1_use_reg;
    logic [lsfe_pkg::POS_W-1:0]      s1_pos_reg;

    lsfe_pkg::item_t  it_reg;
    logic [2:0][14:0] prod_reg;
    logic [2:0][7:0]  sc_reg;
    logic [2:0]       region_reg;
    logic [7:0]       rem_reg;
    logic [15:0]      a0_reg;
    logic [15:0]      a1_reg;
    logic [15:0]      a2_reg;
    logic [7:0]       p_reg;
    logic [7:0]       q_reg;
    logic [7:0]       t_reg;

    logic                           idx_lt;
    logic [lsfe_pkg::COUNT_W-1:0]   end_cl;
    logic                           is_send_cmd;
    logic                           hsv;
    logic [2:0][7:0]                lane;
    logic [8:0]                     h9;
    logic [2:0]                     region;
    logic [8:0]                     base;
    logic [5:0]                     hmod;
    logic [9:0]                     m17;
    logic [7:0]                     px_r;
    logic [7:0]                     px_g;
    logic [7:0]                     px_b;
    logic [lsfe_pkg::PIX_W-1:0]     pix;
    logic [lsfe_pkg::PIX_W-1:0]     ram_q;
    logic [lsfe_pkg::PIX_AW-1:0]    addr;
    logic                           do_write;
    logic [5:0]                     cfg_cnt;

    // status: write check from the offered item, used on the accepting edge; last flags from the pointer
    always_comb
    begin
        idx_lt = item.index < {2'b00, count_reg};
        if (item.end_index >= {2'b00, count_reg})
        begin
            end_cl = count_reg - 1'b1;
        end
        else
        begin
            end_cl = item.end_index[lsfe_pkg::COUNT_W-1:0];
        end
        is_send_cmd = (item.cmd == lsfe_pkg::CMD_SHOW) || (item.cmd == lsfe_pkg::CMD_RELEASE)
                   || (item.cmd == lsfe_pkg::CMD_FLUSH);
        status.write_ok  = idx_lt && ((item.cmd != lsfe_pkg::CMD_FILL)
                         || (item.index[lsfe_pkg::COUNT_W-1:0] <= end_cl));
        status.fill_last = ptr_reg == end_reg;
        status.send_last = ptr_reg == lsfe_pkg::LAST_POS;
    end

    assign hsv      = it_reg.cmd == lsfe_pkg::CMD_SET_HSV;
    assign lane[0]  = hsv ? it_reg.value : it_reg.red;
    assign lane[1]  = it_reg.green;
    assign lane[2]  = it_reg.blue;
    assign addr     = ptr_reg[lsfe_pkg::PIX_AW-1:0];
    assign do_write = ctrl.op == lsfe_pkg::OP_WRITE;

    // hue region and scaled remainder
    always_comb
    begin
        h9 = (it_reg.hue > lsfe_pkg::HUE_MAX) ? 9'd359 : it_reg.hue[8:0];
        if (h9 >= 9'd300)
        begin
            region = 3'd5;
            base   = 9'd300;
        end
        else if (h9 >= 9'd240)
        begin
            region = 3'd4;
            base   = 9'd240;
        end
        else if (h9 >= 9'd180)
        begin
            region = 3'd3;
            base   = 9'd180;
        end
        else if (h9 >= 9'd120)
        begin
            region = 3'd2;
            base   = 9'd120;
        end
        else if (h9 >= 9'd60)
        begin
            region = 3'd1;
            base   = 9'd60;
        end
        else
        begin
            region = 3'd0;
            base   = 9'd0;
        end
        hmod = 6'(h9 - base);
        // (hmod * 255) / 60 == (hmod * 17) / 4
        m17  = {hmod, 4'b0000} + {4'b0000, hmod};
    end

    // final pixel color
    always_comb
    begin
        if (!hsv)
        begin
            px_r = sc_reg[0];
            px_g = sc_reg[1];
            px_b = sc_reg[2];
        end
        else if (it_reg.saturation == 8'd0)
        begin
            px_r = sc_reg[0];
            px_g = sc_reg[0];
            px_b = sc_reg[0];
        end
        else
        begin
            case (region_reg)
                3'd0:
                begin
                    px_r = sc_reg[0];
                    px_g = t_reg;
                    px_b = p_reg;
                end
                3'd1:
                begin
                    px_r = q_reg;
                    px_g = sc_reg[0];
                    px_b = p_reg;
                end
                3'd2:
                begin
                    px_r = p_reg;
                    px_g = sc_reg[0];
                    px_b = t_reg;
                end
                3'd3:
                begin
                    px_r = p_reg;
                    px_g = q_reg;
                    px_b = sc_reg[0];
                end
                3'd4:
                begin
                    px_r = t_reg;
                    px_g = p_reg;
                    px_b = sc_reg[0];
                end
                default:
                begin
                    px_r = sc_reg[0];
                    px_g = p_reg;
                    px_b = q_reg;
                end
            endcase
        end
        pix = {px_g, px_r, px_b};
    end

    assign cfg_cnt = cfg_data[5:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            bright_reg   <= lsfe_pkg::BRIGHT_FULL;
            ptr_reg      <= '0;
            end_reg      <= '0;
            vld_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == lsfe_pkg::REG_LED_COUNT))
            begin
                count_reg <= ({1'b0, cfg_cnt} > 7'(lsfe_pkg::MAX_PIXELS))
                           ? lsfe_pkg::COUNT_W'(lsfe_pkg::MAX_PIXELS) : cfg_cnt;
            end
            if (cfg_we && (cfg_index == lsfe_pkg::REG_BRIGHTNESS))
            begin
                bright_reg <= (cfg_data > lsfe_pkg::BRIGHT_FULL) ? lsfe_pkg::BRIGHT_FULL
                            : cfg_data;
            end
            if (ctrl.load)
            begin
                ptr_reg <= is_send_cmd ? '0 : item.index[lsfe_pkg::COUNT_W-1:0];
                end_reg <= (item.cmd == lsfe_pkg::CMD_FILL) ? end_cl
                         : item.index[lsfe_pkg::COUNT_W-1:0];
            end
            else if (do_write || (ctrl.op == lsfe_pkg::OP_SEND))
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (ctrl.clear_store)
            begin
                vld_reg <= '0;
            end
            else if (do_write)
            begin
                vld_reg[addr] <= 1'b1;
            end
            s1_valid_reg <= ctrl.op == lsfe_pkg::OP_SEND;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            it_reg <= item;
        end
        case (ctrl.op)
            lsfe_pkg::OP_SCALE_MUL:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[c] <= 15'(lane[c] * bright_reg);
                end
                region_reg <= region;
                rem_reg    <= m17[9:2];
            end
            lsfe_pkg::OP_SCALE_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (bright_reg < lsfe_pkg::BRIGHT_FULL)
                    begin
                        sc_reg[c] <= 8'((28'(prod_reg[c]) * 28'(lsfe_pkg::DIV100_MUL))
                                     >> lsfe_pkg::DIV100_SHIFT);
                    end
                    else
                    begin
                        sc_reg[c] <= lane[c];
                    end
                end
            end
            lsfe_pkg::OP_HSV1:
            begin
                a0_reg <= 16'(sc_reg[0] * (8'd255 - it_reg.saturation));
                a1_reg <= 16'(it_reg.saturation * rem_reg);
                a2_reg <= 16'(it_reg.saturation * (8'd255 - rem_reg));
            end
            lsfe_pkg::OP_HSV2:
            begin
                p_reg <= lsfe_pkg::div255(a0_reg);
                q_reg <= lsfe_pkg::div255(a1_reg);
                t_reg <= lsfe_pkg::div255(a2_reg);
            end
            lsfe_pkg::OP_HSV3:
            begin
                a1_reg <= 16'(sc_reg[0] * (8'd255 - q_reg));
                a2_reg <= 16'(sc_reg[0] * (8'd255 - t_reg));
            end
            lsfe_pkg::OP_HSV4:
            begin
                q_reg <= lsfe_pkg::div255(a1_reg);
                t_reg <= lsfe_pkg::div255(a2_reg);
            end
            default:
            begin
            end
        endcase
        s1_pos_reg <= ptr_reg;
        s1_use_reg <= (ptr_reg < count_reg) && vld_reg[addr];
    end

    lsfe_ram #(
        .WIDTH (lsfe_pkg::PIX_W),
        .DEPTH (lsfe_pkg::MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (addr),
        .wdata (pix),
        .raddr (addr),
        .rdata (ram_q)
    );

    assign result_valid        = s1_valid_reg;
    assign result.grb_word     = s1_use_reg ? ram_q : '0;
    assign result.led_position = s1_pos_reg;
    assign result.last         = s1_pos_reg == lsfe_pkg::LAST_POS;

endmodule

/* rtl/core/lsfe_ctrl.sv */
// Controller: command sequencing state machine and blank-frame flag.
module lsfe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0]           cmd,
    input  logic                 link_busy,
    input  lsfe_pkg::dp_status_t status,
    output lsfe_pkg::ctrl_t      ctrl,
    output logic                 busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE_MUL,
        S_SCALE_DIV,
        S_HSV1,
        S_HSV2,
        S_HSV3,
        S_HSV4,
        S_WRITE,
        S_SEND,
        S_DRAIN
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] cmd_reg;
    logic [2:0] cmd_next;
    logic       blank_reg;
    logic       blank_next;
    logic       busy_reg;
    logic       accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        blank_next       = blank_reg;
        ctrl.load        = accept;
        ctrl.clear_store = 1'b0;
        ctrl.op          = lsfe_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    case (cmd)
                        lsfe_pkg::CMD_SET_RGB,
                        lsfe_pkg::CMD_SET_HSV,
                        lsfe_pkg::CMD_FILL:
                        begin
                            if (status.write_ok)
                            begin
                                state_next = S_SCALE_MUL;
                            end
                        end
                        lsfe_pkg::CMD_CLEAR:
                        begin
                            ctrl.clear_store = 1'b1;
                        end
                        lsfe_pkg::CMD_SHOW:
                        begin
                            if (!link_busy)
                            begin
                                state_next = S_SEND;
                                blank_next = 1'b0;
                            end
                        end
                        lsfe_pkg::CMD_RELEASE:
                        begin
                            ctrl.clear_store = 1'b1;
                            blank_next       = link_busy;
                            if (!link_busy)
                            begin
                                state_next = S_SEND;
                            end
                        end
                        lsfe_pkg::CMD_FLUSH:
                        begin
                            if (blank_reg && !link_busy)
                            begin
                                state_next = S_SEND;
                                blank_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCALE_MUL:
            begin
                ctrl.op    = lsfe_pkg::OP_SCALE_MUL;
                state_next = S_SCALE_DIV;
            end
            S_SCALE_DIV:
            begin
                ctrl.op    = lsfe_pkg::OP_SCALE_DIV;
                state_next = (cmd_reg == lsfe_pkg::CMD_SET_HSV) ? S_HSV1 : S_WRITE;
            end
            S_HSV1:
            begin
                ctrl.op    = lsfe_pkg::OP_HSV1;
                state_next = S_HSV2;
            end
            S_HSV2:
            begin
                ctrl.op    = lsfe_pkg::OP_HSV2;
                state_next = S_HSV3;
            end
            S_HSV3:
            begin
                ctrl.op    = lsfe_pkg::OP_HSV3;
                state_next = S_HSV4;
            end
            S_HSV4:
            begin
                ctrl.op    = lsfe_pkg::OP_HSV4;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ctrl.op = lsfe_pkg::OP_WRITE;
                if (status.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEND:
            begin
                ctrl.op = lsfe_pkg::OP_SEND;
                if (status.send_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= lsfe_pkg::CMD_SET_RGB;
            blank_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            blank_reg <= blank_next;
            busy_reg  <= state_next != S_IDLE;
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/core/led_strip_frame_encoder.sv */
// Top level of the LED strip frame encoder: controller plus datapath.
//
// Channel    | Handshake                     | Payload
// -----------+-------------------------------+---------------------------------
// command    | start, busy (take: start&!busy)| item   (lsfe_pkg::item_t)
// frame out  | result_valid, one-cycle strobe | result (lsfe_pkg::result_t)
// config     | cfg_we, cfg_index              | cfg_data (7 bits)
//
// Busy rises at the accepting edge and holds while a transaction runs: set rgb
// through scale and write, set hsv through scale, the four conversion steps and
// write, fill through scale and one write per pixel, a sent frame through one
// store read per strip position via the registered RAM port, then the last word;
// clear and refused or empty commands leave busy low, so the next transaction can
// be taken at the very next edge. Busy stays up until the last frame word is out.
// Reset clears the store at once through per-pixel valid bits; no clearing pass.
// The receiver cannot stall: each frame word is presented for exactly one cycle.
module led_strip_frame_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lsfe_pkg::item_t                  item,
    output logic                             result_valid,
    output lsfe_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [lsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // command and status between sequencer and datapath
    lsfe_pkg::ctrl_t      ctrl;
    lsfe_pkg::dp_status_t status;

    // sequence each transaction: scale, convert, write or walk the strip
    lsfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (item.cmd),
        .link_busy (item.link_busy),
        .status    (status),
        .ctrl      (ctrl),
        .busy      (busy)
    );

    // hold config, compute colors, store pixels and drive frame words
    lsfe_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* rtl/core/lsfe_checker.sv */
// Port-level checks on frame output behavior, bound to the top level.
module lsfe_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_valid,
    input lsfe_pkg::result_t result
);

    // frame words only while a transaction is in progress
    a_word_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("frame word outside a transaction");

    // words of a frame come back to back
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a frame");

    // positions advance by one
    a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=>
            result.led_position == 6'($past(result.led_position) + 1'b1))
        else $error("strip position did not advance by one");

    // a frame ends after its last word
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("word right after the last word of a frame");

    // a frame starts at position zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> result.led_position == 6'd0)
        else $error("frame did not start at position zero");

endmodule

bind led_strip_frame_encoder lsfe_checker u_lsfe_checker (.*);
